[rtl/lcss_pkg.sv]
// shared constants and types for the lcss trajectory similarity unit
package lcss_pkg;

	localparam int MAX_POINTS_DEF = 256;

	localparam int EPS_W      = 31;
	localparam int GAP_W      = 9;
	localparam int CRD_W      = 32;
	localparam int PT_W       = 2 * CRD_W;
	localparam int SIM_W      = 16;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(65536);
	localparam logic [GAP_W-1:0] GAP_RST = GAP_W'(256);

	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_DROP  = 2'd2;

	// point store write from the load side
	typedef struct packed {
		logic            we_first;
		logic            we_second;
		logic [PT_W-1:0] data;
	} pt_wr_t;

	// table fill control
	typedef struct packed {
		logic start;
		logic rev_en;
	} fill_ctl_t;

endpackage

[rtl/lcss_ram.sv]
// generic single-write single-read ram with registered read
module lcss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

[rtl/lcss_div.sv]
// restoring divider, one quotient bit per cycle, for the q0.16 similarity
module lcss_div #(
	parameter int CNT_W = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [CNT_W-1:0]          count,
	input  logic [CNT_W:0]            divisor,
	output logic                      done,
	output logic [lcss_pkg::SIM_W-1:0] quotient
);
	import lcss_pkg::*;

	localparam int NB    = CNT_W + SIM_W;
	localparam int STP_W = $clog2(NB + 1);

	logic [NB-1:0]      num_q;
	logic [CNT_W+1:0]   rem_q;
	logic [CNT_W:0]     div_q;
	logic [STP_W-1:0]   step_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W+1:0]   rem_sh;
	logic               ge;

	assign rem_sh = {rem_q[CNT_W:0], num_q[NB-1]};
	assign ge     = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STP_W'(NB - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STP_W'(1);
				if (step_q == STP_W'(NB - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {count, {SIM_W{1'b0}}};
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
			num_q <= {num_q[NB-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q[SIM_W-1:0];
endmodule

[rtl/lcss_fill.sv]
// point stores, lcss row memory and the pipelined cell sequencer
module lcss_fill #(
	parameter int MAX_POINTS = lcss_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lcss_pkg::pt_wr_t                  pt_wr,
	input  logic [$clog2(MAX_POINTS)-1:0]     pt_addr,
	input  lcss_pkg::fill_ctl_t               ctl,
	input  logic [$clog2(MAX_POINTS+1)-1:0]   n_len,
	input  logic [$clog2(MAX_POINTS+1)-1:0]   m_len,
	input  logic [lcss_pkg::EPS_W-1:0]        eps,
	input  logic [lcss_pkg::GAP_W-1:0]        gap,
	output logic                              done,
	output logic [$clog2(MAX_POINTS+1)-1:0]   count
);
	import lcss_pkg::*;

	localparam int LEN_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int GW     = (ADDR_W > GAP_W) ? ADDR_W : GAP_W;
	localparam int SQ_W   = 2 * EPS_W;

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_SETUP = 7'b0000010,
		F_CLEAR = 7'b0000100,
		F_ROWRD = 7'b0001000,
		F_ROWWT = 7'b0010000,
		F_RUN   = 7'b0100000,
		F_DRAIN = 7'b1000000
	} fstate_t;

	fstate_t state_q;

	logic [ADDR_W-1:0] i_q, j_q;
	logic [LEN_W-1:0]  clr_q;
	logic              pass_q, rev_q;
	logic [SQ_W-1:0]   eps_sq_q;
	logic [PT_W-1:0]   p_q;
	logic [LEN_W-1:0]  left_q, diag_q, res_q, best_q;
	logic              done_q;

	logic              v_s1, v_s2, v_s3;
	logic [ADDR_W-1:0] j_s1, j_s2, j_s3;
	logic              near_s2, near_s3;
	logic [LEN_W-1:0]  up_s2, up_s3;
	logic [EPS_W-1:0]  dx_s2, dy_s2;
	logic [SQ_W-1:0]   dxsq_s3, dysq_s3;

	logic [PT_W-1:0]   first_rd, second_rd;
	logic [LEN_W-1:0]  tab_rd;
	logic [ADDR_W-1:0] first_raddr;
	logic [LEN_W-1:0]  rev_idx;
	logic              tab_we;
	logic [LEN_W-1:0]  tab_waddr, tab_wdata, tab_raddr;

	logic signed [CRD_W:0] dxw, dyw;
	logic [CRD_W:0]        absx, absy;
	logic [GW-1:0]         ig, jg, gd;
	logic                  near_c;
	logic [SQ_W:0]         dsum;
	logic                  hit;
	logic [LEN_W-1:0]      cell_new, best_pick;
	logic                  empty;
	logic                  fin;

	assign rev_idx     = n_len - LEN_W'(1) - LEN_W'(i_q);
	assign first_raddr = pass_q ? rev_idx[ADDR_W-1:0] : i_q;
	assign tab_raddr   = LEN_W'(j_q) + LEN_W'(1);

	assign tab_we    = (state_q == F_CLEAR) || v_s3;
	assign tab_waddr = (state_q == F_CLEAR) ? clr_q : (LEN_W'(j_s3) + LEN_W'(1));
	assign tab_wdata = (state_q == F_CLEAR) ? '0 : cell_new;

	// last row of the last pass has fully drained
	assign fin = (state_q == F_DRAIN) && empty && (LEN_W'(i_q) == n_len - LEN_W'(1))
		&& !(!pass_q && rev_q);

	lcss_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_first (
		.clk(clk), .we(pt_wr.we_first), .waddr(pt_addr), .wdata(pt_wr.data),
		.raddr(first_raddr), .rdata(first_rd)
	);

	lcss_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_second (
		.clk(clk), .we(pt_wr.we_second), .waddr(pt_addr), .wdata(pt_wr.data),
		.raddr(j_q), .rdata(second_rd)
	);

	lcss_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS + 1)) u_row (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rd)
	);

	// stage 1: coordinate differences and index gap
	always_comb begin
		dxw  = $signed({p_q[PT_W-1], p_q[PT_W-1:CRD_W]})
			- $signed({second_rd[PT_W-1], second_rd[PT_W-1:CRD_W]});
		dyw  = $signed({p_q[CRD_W-1], p_q[CRD_W-1:0]})
			- $signed({second_rd[CRD_W-1], second_rd[CRD_W-1:0]});
		absx = dxw[CRD_W] ? (CRD_W+1)'(-dxw) : (CRD_W+1)'(dxw);
		absy = dyw[CRD_W] ? (CRD_W+1)'(-dyw) : (CRD_W+1)'(dyw);
		ig   = GW'(i_q);
		jg   = GW'(j_s1);
		gd   = (ig > jg) ? (ig - jg) : (jg - ig);
		near_c = (absx < (CRD_W+1)'(eps)) && (absy < (CRD_W+1)'(eps))
			&& (gd <= GW'(gap));
	end

	// stage 3: squared distance test and cell update
	always_comb begin
		dsum     = {1'b0, dxsq_s3} + {1'b0, dysq_s3};
		hit      = near_s3 && (dsum < {1'b0, eps_sq_q});
		cell_new = hit ? (diag_q + LEN_W'(1)) : ((up_s3 > left_q) ? up_s3 : left_q);
		best_pick = (res_q < best_q) ? res_q : best_q;
		empty    = !(v_s1 || v_s2 || v_s3);
	end

	always_ff @(posedge clk) begin
		j_s1    <= j_q;
		j_s2    <= j_s1;
		near_s2 <= near_c;
		up_s2   <= tab_rd;
		dx_s2   <= absx[EPS_W-1:0];
		dy_s2   <= absy[EPS_W-1:0];
		j_s3    <= j_s2;
		near_s3 <= near_s2;
		up_s3   <= up_s2;
		dxsq_s3 <= dx_s2 * dx_s2;
		dysq_s3 <= dy_s2 * dy_s2;
		if (state_q == F_SETUP) begin
			eps_sq_q <= eps * eps;
		end
		if (state_q == F_ROWWT) begin
			p_q    <= first_rd;
			left_q <= '0;
			diag_q <= '0;
		end else if (v_s3) begin
			left_q <= cell_new;
			diag_q <= up_s3;
			if (j_s3 == ADDR_W'(m_len - LEN_W'(1))) begin
				res_q <= cell_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			clr_q   <= '0;
			pass_q  <= 1'b0;
			rev_q   <= 1'b0;
			best_q  <= '0;
			done_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			done_q <= fin;
			v_s1   <= (state_q == F_RUN);
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			unique case (state_q)
				F_IDLE: begin
					if (ctl.start) begin
						rev_q   <= ctl.rev_en;
						state_q <= F_SETUP;
					end
				end
				F_SETUP: begin
					clr_q   <= LEN_W'(1);
					i_q     <= '0;
					pass_q  <= 1'b0;
					state_q <= F_CLEAR;
				end
				F_CLEAR: begin
					clr_q <= clr_q + LEN_W'(1);
					if (clr_q == m_len) begin
						state_q <= F_ROWRD;
					end
				end
				F_ROWRD: begin
					state_q <= F_ROWWT;
				end
				F_ROWWT: begin
					j_q     <= '0;
					state_q <= F_RUN;
				end
				F_RUN: begin
					if (LEN_W'(j_q) == m_len - LEN_W'(1)) begin
						state_q <= F_DRAIN;
					end else begin
						j_q <= j_q + ADDR_W'(1);
					end
				end
				F_DRAIN: begin
					// wait for the row's last write before the next row reads it
					if (empty) begin
						if (LEN_W'(i_q) == n_len - LEN_W'(1)) begin
							best_q <= pass_q ? best_pick : res_q;
							if (!pass_q && rev_q) begin
								pass_q  <= 1'b1;
								i_q     <= '0;
								clr_q   <= LEN_W'(1);
								state_q <= F_CLEAR;
							end else begin
								state_q <= F_IDLE;
							end
						end else begin
							i_q     <= i_q + ADDR_W'(1);
							state_q <= F_ROWRD;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign count = best_q;
endmodule

[rtl/lcss_trajectory_similarity_unit.sv]
// top level of the lcss trajectory similarity unit
//
//  channel | handshake          | word
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | req_type, coord_x, coord_y, last_point
//  out     | out_valid/out_stall| match_count, similarity, status
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// points load one per cycle; in_stall rises once both trajectories are complete.
// scoring clears the m row entries in each pass, then runs one cell
// per cycle through the row memory, with a drain at each row end; reverse mode
// runs two passes. the similarity divide then follows the scoring.
// reset clears lengths, flags and registers; point stores are left as they are.
// a finished result waits in the output register while new points load.
module lcss_trajectory_similarity_unit #(
	parameter int MAX_POINTS = lcss_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic signed [lcss_pkg::CRD_W-1:0]   coord_x,
	input  logic signed [lcss_pkg::CRD_W-1:0]   coord_y,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [$clog2(MAX_POINTS+1)-1:0]     match_count,
	output logic [lcss_pkg::SIM_W-1:0]          similarity,
	output logic [lcss_pkg::STAT_W-1:0]         status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lcss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcss_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lcss_pkg::*;

	localparam int LEN_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = $clog2(MAX_POINTS);

	typedef enum logic [4:0] {
		T_LOAD = 5'b00001,
		T_CHK  = 5'b00010,
		T_FILL = 5'b00100,
		T_DIV  = 5'b01000,
		T_OUT  = 5'b10000
	} tstate_t;

	tstate_t state_q;

	logic [EPS_W-1:0]  eps_q;
	logic [GAP_W-1:0]  gap_q;
	logic              rev_q;
	logic [LEN_W-1:0]  first_len_q, second_len_q;
	logic              first_done_q, second_done_q, ovf_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [SIM_W-1:0]  sim_q;
	logic [STAT_W-1:0] stat_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_cnt_q;
	logic [SIM_W-1:0]  out_sim_q;
	logic [STAT_W-1:0] out_stat_q;

	logic              acc, sel_done, room, is_short;
	logic [LEN_W-1:0]  sel_len, shorter;
	pt_wr_t            pt_wr;
	fill_ctl_t         fctl;
	logic              fill_done, div_done;
	logic [LEN_W-1:0]  fill_count;
	logic [SIM_W-1:0]  div_q;

	assign in_stall  = (state_q != T_LOAD);
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && !in_stall;
	assign sel_done  = req_type ? second_done_q : first_done_q;
	assign sel_len   = req_type ? second_len_q : first_len_q;
	assign room      = sel_len < LEN_W'(MAX_POINTS);
	assign is_short  = (first_len_q < LEN_W'(2)) || (second_len_q < LEN_W'(2));
	assign shorter   = (first_len_q < second_len_q) ? first_len_q : second_len_q;

	assign pt_wr.we_first  = acc && !req_type && !sel_done && room;
	assign pt_wr.we_second = acc && req_type && !sel_done && room;
	assign pt_wr.data      = {coord_x, coord_y};

	assign fctl.start  = (state_q == T_CHK) && !is_short;
	assign fctl.rev_en = rev_q;

	lcss_fill #(.MAX_POINTS(MAX_POINTS)) u_fill (
		.clk(clk), .arst_n(arst_n),
		.pt_wr(pt_wr), .pt_addr(sel_len[ADDR_W-1:0]), .ctl(fctl),
		.n_len(first_len_q), .m_len(second_len_q),
		.eps(eps_q), .gap(gap_q),
		.done(fill_done), .count(fill_count)
	);

	lcss_div #(.CNT_W(LEN_W)) u_div (
		.clk(clk), .arst_n(arst_n),
		.start(fill_done), .count(fill_count),
		.divisor({1'b0, shorter} + (LEN_W+1)'(1)),
		.done(div_done), .quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
			gap_q <= GAP_RST;
			rev_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EPSILON: eps_q <= cfg_data[EPS_W-1:0];
				CFG_GAP:     gap_q <= cfg_data[GAP_W-1:0];
				CFG_REVERSE: rev_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_CHK) begin
			cnt_q  <= '0;
			sim_q  <= '0;
			stat_q <= STATUS_SHORT;
		end
		if (fill_done) begin
			cnt_q <= fill_count;
		end
		if (div_done) begin
			sim_q  <= div_q;
			stat_q <= ovf_q ? STATUS_DROP : STATUS_OK;
		end
		if ((state_q == T_OUT) && (!out_valid_q || !out_stall)) begin
			out_cnt_q  <= cnt_q;
			out_sim_q  <= sim_q;
			out_stat_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_LOAD;
			first_len_q   <= '0;
			second_len_q  <= '0;
			first_done_q  <= 1'b0;
			second_done_q <= 1'b0;
			ovf_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if ((state_q == T_OUT) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_LOAD: begin
					// a point for an already complete trajectory is ignored
					if (acc && !sel_done) begin
						if (room) begin
							if (req_type) begin
								second_len_q <= second_len_q + LEN_W'(1);
							end else begin
								first_len_q <= first_len_q + LEN_W'(1);
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_point) begin
							if (req_type) begin
								second_done_q <= 1'b1;
							end else begin
								first_done_q <= 1'b1;
							end
							if (req_type ? first_done_q : second_done_q) begin
								state_q <= T_CHK;
							end
						end
					end
				end
				T_CHK: begin
					state_q <= is_short ? T_OUT : T_FILL;
				end
				T_FILL: begin
					if (fill_done) begin
						state_q <= T_DIV;
					end
				end
				T_DIV: begin
					if (div_done) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (!out_valid_q || !out_stall) begin
						first_len_q   <= '0;
						second_len_q  <= '0;
						first_done_q  <= 1'b0;
						second_done_q <= 1'b0;
						ovf_q         <= 1'b0;
						state_q       <= T_LOAD;
					end
				end
				default: state_q <= T_LOAD;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = out_cnt_q;
	assign similarity  = out_sim_q;
	assign status      = out_stat_q;
endmodule

[rtl/lcss_checker.sv]
// port-level checks on the lcss trajectory similarity unit
module lcss_checker #(
	parameter int MAX_POINTS = lcss_pkg::MAX_POINTS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [$clog2(MAX_POINTS+1)-1:0]    match_count,
	input logic [lcss_pkg::SIM_W-1:0]         similarity,
	input logic [lcss_pkg::STAT_W-1:0]        status
);
	import lcss_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_count)
			&& $stable(similarity) && $stable(status))
		else $error("stalled result word changed");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_SHORT) |-> (match_count == '0) && (similarity == '0))
		else $error("short trajectory result carries a nonzero score");

	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (match_count == '0) |-> (similarity == '0))
		else $error("nonzero similarity with zero match count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK) || (status == STATUS_SHORT)
			|| (status == STATUS_DROP))
		else $error("undefined status code");
endmodule

bind lcss_trajectory_similarity_unit lcss_checker #(.MAX_POINTS(MAX_POINTS)) u_lcss_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.match_count(match_count), .similarity(similarity), .status(status)
);

[tb/tb_lcss_trajectory_similarity_unit.sv]
// self-checking testbench for the lcss trajectory similarity unit
`timescale 1ns / 100ps

module tb_lcss_trajectory_similarity_unit;
	import lcss_pkg::*;

	localparam int NPTS      = MAX_POINTS_DEF;
	localparam int CNT_W     = $clog2(NPTS + 1);
	localparam int LIMIT     = 3000000;
	localparam int SETTLE    = 40;
	localparam bit FIRST_TR  = 1'b0;
	localparam bit SECOND_TR = 1'b1;

	typedef struct {
		bit          rt;
		logic [31:0] x;
		logic [31:0] y;
		bit          last;
	} point_t;

	typedef struct {
		logic [CNT_W-1:0]  cnt;
		logic [SIM_W-1:0]  sim;
		logic [STAT_W-1:0] st;
	} score_t;

	typedef struct {
		point_t p;
		bit     fixed;
		score_t s;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    req_type;
	logic signed [CRD_W-1:0] coord_x;
	logic signed [CRD_W-1:0] coord_y;
	logic                    last_point;
	logic                    out_valid;
	logic                    out_stall;
	logic [CNT_W-1:0]        match_count;
	logic [SIM_W-1:0]        similarity;
	logic [STAT_W-1:0]       status;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	lcss_trajectory_similarity_unit dut (.*);

	// predictor state
	logic [PT_W-1:0]  first_pts [NPTS];
	logic [PT_W-1:0]  second_pts [NPTS];
	int unsigned      first_len, second_len;
	bit               first_done, second_done, dropped;
	longint unsigned  eps_cfg;
	int unsigned      gap_cfg;
	bit               rev_cfg;

	score_t score_q[$];
	int     errors;
	int     cycles;
	int     idle_pct, stall_pct, hold_left;
	int     phase_items;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_lcss_trajectory_similarity_unit: FAIL");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off while hold_left runs down
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic report(string what, longint exp_v, longint got_v);
		$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (score_q.size() == 0) begin
				report("unexpected word, match_count", -1, match_count);
			end else begin
				score_t e;
				e = score_q.pop_front();
				if (match_count !== e.cnt) report("match_count", e.cnt, match_count);
				if (similarity !== e.sim) report("similarity", e.sim, similarity);
				if (status !== e.st) report("status", e.st, status);
			end
		end
	end

	function automatic bit near(logic [PT_W-1:0] p, logic [PT_W-1:0] q);
		longint ax, ay, bx, by;
		longint unsigned dx, dy;
		ax = longint'($signed(p[63:32]));
		ay = longint'($signed(p[31:0]));
		bx = longint'($signed(q[63:32]));
		by = longint'($signed(q[31:0]));
		dx = ax > bx ? ax - bx : bx - ax;
		dy = ay > by ? ay - by : by - ay;
		if (dx >= eps_cfg || dy >= eps_cfg)
			return 1'b0;
		return dx * dx + dy * dy < eps_cfg * eps_cfg;
	endfunction

	function automatic int unsigned lcss_len(bit rev);
		int unsigned row [0:NPTS];
		int unsigned diag, up, gap;
		logic [PT_W-1:0] p;
		for (int j = 0; j <= second_len; j++)
			row[j] = 0;
		for (int i = 0; i < first_len; i++) begin
			p = rev ? first_pts[first_len-1-i] : first_pts[i];
			diag = 0;
			for (int j = 0; j < second_len; j++) begin
				up = row[j+1];
				gap = i > j ? i - j : j - i;
				if (gap <= gap_cfg && near(p, second_pts[j]))
					row[j+1] = diag + 1;
				else
					row[j+1] = up > row[j] ? up : row[j];
				diag = up;
			end
		end
		return row[second_len];
	endfunction

	task automatic score_point(input point_t pt, output bit got, output score_t s);
		int unsigned cnt, rc, shorter;
		got = 1'b0;
		s = '{default: '0};
		if (pt.rt == SECOND_TR ? second_done : first_done)
			return;
		if (pt.rt == SECOND_TR) begin
			if (second_len < NPTS) second_pts[second_len++] = {pt.x, pt.y};
			else dropped = 1'b1;
			if (pt.last) second_done = 1'b1;
		end else begin
			if (first_len < NPTS) first_pts[first_len++] = {pt.x, pt.y};
			else dropped = 1'b1;
			if (pt.last) first_done = 1'b1;
		end
		if (!(first_done && second_done))
			return;
		got = 1'b1;
		if (first_len < 2 || second_len < 2) begin
			s.st = STATUS_SHORT;
		end else begin
			shorter = first_len < second_len ? first_len : second_len;
			cnt = lcss_len(1'b0);
			if (rev_cfg) begin
				rc = lcss_len(1'b1);
				if (rc < cnt) cnt = rc;
			end
			s.cnt = cnt;
			s.sim = SIM_W'((longint'(cnt) << 16) / (shorter + 1));
			s.st = dropped ? STATUS_DROP : STATUS_OK;
		end
		first_len = 0;
		second_len = 0;
		first_done = 1'b0;
		second_done = 1'b0;
		dropped = 1'b0;
	endtask

	task automatic send_point(point_t pt, bit fixed = 1'b0, score_t fix_s = '{default: '0});
		bit got;
		score_t s;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= pt.rt;
		coord_x    <= pt.x;
		coord_y    <= pt.y;
		last_point <= pt.last;
		do @(posedge clk); while (in_stall);
		score_point(pt, got, s);
		if (got) score_q.push_back(fixed ? fix_s : s);
		phase_items++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_EPSILON: eps_cfg = val;
			CFG_GAP:     gap_cfg = val[GAP_W-1:0];
			CFG_REVERSE: rev_cfg = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (score_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] jitter(logic [31:0] v, longint unsigned span);
		longint unsigned r;
		r = $urandom_range(32'(2 * span));
		return v + 32'(r) - 32'(span);
	endfunction

	// two trajectories, interleaved at random, the second tracking the first unless noise is set
	task automatic send_pair(int n1, int n2, bit noise);
		point_t a [$];
		point_t b [$];
		point_t pt;
		longint unsigned span;
		logic [31:0] bx, by;
		int shift, i1, i2;
		span = eps_cfg >> 1;
		if (span == 0) span = 16;
		if (span > (1 << 28)) span = 1 << 28;
		bx = noise ? $urandom : 32'($urandom_range(1 << 24));
		by = noise ? $urandom : 32'($urandom_range(1 << 24));
		for (int i = 0; i < n1; i++) begin
			pt.rt = FIRST_TR;
			pt.x = noise ? $urandom : jitter(bx, span * 4);
			pt.y = noise ? $urandom : jitter(by, span * 4);
			pt.last = (i == n1 - 1);
			a.push_back(pt);
			bx = pt.x;
			by = pt.y;
		end
		shift = $urandom_range(2);
		for (int j = 0; j < n2; j++) begin
			pt.rt = SECOND_TR;
			if (!noise && $urandom_range(3) != 0 && j + shift < n1) begin
				pt.x = jitter(a[j+shift].x, span);
				pt.y = jitter(a[j+shift].y, span);
			end else begin
				pt.x = noise ? $urandom : jitter(bx, span * 4);
				pt.y = noise ? $urandom : jitter(by, span * 4);
			end
			pt.last = (j == n2 - 1);
			b.push_back(pt);
		end
		i1 = 0;
		i2 = 0;
		while (i1 < n1 || i2 < n2) begin
			if (i2 >= n2 || (i1 < n1 && $urandom_range(1))) begin
				send_point(a[i1++]);
				// stray point for a completed trajectory
				if (i1 == n1 && i2 < n2 && $urandom_range(5) == 0) begin
					pt = a[0];
					pt.x = $urandom;
					send_point(pt);
				end
			end else begin
				send_point(b[i2++]);
			end
		end
	endtask

	task automatic random_phase(int items);
		int n1, n2;
		phase_items = 0;
		while (phase_items < items) begin
			n1 = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
			n2 = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
			send_pair(n1, n2, $urandom_range(4) == 0);
		end
		stop_sending();
	endtask

	dir_row_t dir_tab [19];

	initial begin
		int unsigned eps_set [8];
		int unsigned gap_set [8];
		bit          rev_set [8];
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = 1'b0;
		coord_x = '0;
		coord_y = '0;
		last_point = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_EPSILON;
		cfg_data = '0;
		first_len = 0;
		second_len = 0;
		first_done = 1'b0;
		second_done = 1'b0;
		dropped = 1'b0;
		eps_cfg = EPS_RST;
		gap_cfg = GAP_RST;
		rev_cfg = 1'b0;

		dir_tab = '{
			// one point each: short
			'{'{FIRST_TR, 32'h0, 32'h0, 1'b1}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h0, 32'h0, 1'b1}, 1'b1, '{0, 0, STATUS_SHORT}},
			// identical pairs at the coordinate extremes
			'{'{FIRST_TR, 32'h7fffffff, 32'h80000000, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'h80000000, 32'h7fffffff, 1'b1}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h7fffffff, 32'h80000000, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h80000000, 32'h7fffffff, 1'b1}, 1'b1, '{2, 43690, STATUS_OK}},
			// far apart, with a stray point after the first completes
			'{'{FIRST_TR, 32'h0, 32'h0, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'h0, 32'h0, 1'b1}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'hffffffff, 32'hffffffff, 1'b1}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h40000000, 32'h0, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h40000000, 32'h0, 1'b1}, 1'b1, '{0, 0, STATUS_OK}},
			// second first, first has three points but second is short
			'{'{SECOND_TR, 32'h5, 32'h5, 1'b1}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'h5, 32'h5, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'h5, 32'h5, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'h5, 32'h5, 1'b1}, 1'b1, '{0, 0, STATUS_SHORT}},
			// just under and just over epsilon apart
			'{'{FIRST_TR, 32'h0, 32'h0, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{FIRST_TR, 32'h100, 32'h0, 1'b1}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h0, 32'hffff, 1'b0}, 1'b0, '{0, 0, STATUS_OK}},
			'{'{SECOND_TR, 32'h100, 32'h10000, 1'b1}, 1'b0, '{0, 0, STATUS_OK}}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k])
			send_point(dir_tab[k].p, dir_tab[k].fixed, dir_tab[k].s);
		send_pair(1, 1, 1'b0);
		send_pair(2, 3, 1'b0);
		// over capacity on the first trajectory
		send_pair(NPTS + 2, 3, 1'b0);
		stop_sending();
		drain();

		eps_set = '{0, 32'h7fffffff, 65536, 300000, 1000, 65536, 4000000, 1};
		gap_set = '{256, 256, 0, 3, 511, 1, 2, 256};
		rev_set = '{0, 1, 1, 0, 1, 0, 1, 0};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_EPSILON, eps_set[ph]);
			write_reg(CFG_GAP, gap_set[ph]);
			write_reg(CFG_REVERSE, rev_set[ph]);
			idle_pct  = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 23 : 0;
			stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 23 : 0;
			if (ph == 2) hold_left = 600;
			if (ph == 1) begin
				// full size pair, both passes
				send_pair(NPTS, NPTS, 1'b0);
				stop_sending();
				drain();
			end
			random_phase(70);
			drain();
		end

		if (score_q.size() != 0) begin
			$display("%0d results never arrived", score_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_lcss_trajectory_similarity_unit: PASS");
		else
			$display("tb_lcss_trajectory_similarity_unit: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/lcss_pkg.sv
rtl/lcss_ram.sv
rtl/lcss_div.sv
rtl/lcss_fill.sv
rtl/lcss_trajectory_similarity_unit.sv
rtl/lcss_checker.sv
tb/tb_lcss_trajectory_similarity_unit.sv
